FILE: rtl/core/kmsm_pkg.sv
// ----------------------------------------------------------------------------
// kmsm_pkg
// Shared types and constants for the streaming prefix matcher: request kinds,
// symbol width, default pattern capacity and the per-cell control bundle.
// ----------------------------------------------------------------------------
package kmsm_pkg;

   localparam int MAX_PATTERN_DEF = 64;
   localparam int SYM_W           = 8;
   localparam int KIND_W          = 2;

   // request kinds; the remaining code is ignored by the core
   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'b00,
      KIND_TEXT   = 2'b01,
      KIND_CLEAR  = 2'b10
   } kind_type;

   // control broadcast from the core to every cell of the row
   typedef struct packed {
      logic             step_text; // advance the prefix flags by one text symbol
      logic             append;    // load a pattern symbol at the current length
      logic             clear;     // drop pattern and match state
      logic             drop;      // drop match state after the final text symbol
      logic [SYM_W-1:0] sym;
   } cell_ctl_type;

endpackage

FILE: rtl/core/kmsm_cell.sv
// ----------------------------------------------------------------------------
// kmsm_cell
// One position of the pattern row. Holds pattern symbol IDX and the flag
// "pattern prefix of length IDX+1 ends the text seen so far", and hands its
// flag to the next cell on each text symbol.
// ----------------------------------------------------------------------------
module kmsm_cell
   import kmsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int IDX         = 0,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [LEN_W-1:0] length,
   input  logic             prev_flag,
   output logic             flag_ff,
   output logic             tail_hit
);

   localparam logic [LEN_W-1:0] IDX_L  = LEN_W'(IDX);
   localparam logic [LEN_W-1:0] IDX_P1 = LEN_W'(IDX + 1);

   logic [SYM_W-1:0] sym_ff;
   logic             flag_in;
   logic             active;
   logic             tail;
   logic             hit;

   // compare against the stored symbol for cells inside the pattern
   assign active = (IDX_L < length);
   assign tail   = (IDX_P1 == length);
   assign hit    = prev_flag && active && (sym_ff == ctl.sym);

   // a full-length hit is reported but never kept: the match falls back
   assign tail_hit = ctl.step_text && hit && tail;

   always_comb begin
      flag_in = flag_ff;
      if (ctl.clear || ctl.drop) begin
         flag_in = 1'b0;
      end else if (ctl.step_text) begin
         flag_in = hit && !tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   // load the pattern symbol when this cell is the next free position
   always_ff @(posedge clock) begin
      if (ctl.append && (IDX_L == length)) begin
         sym_ff <= ctl.sym;
      end
   end

endmodule

FILE: rtl/core/kmsm_encoder.sv
// ----------------------------------------------------------------------------
// kmsm_encoder
// Longest live prefix: position of the highest set flag of the row, plus one,
// or zero when no flag is set.
// ----------------------------------------------------------------------------
module kmsm_encoder
   import kmsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic [MAX_PATTERN-1:0] flags,
   output logic [LEN_W-1:0]       length
);

   // pick the highest set flag; later hits override earlier ones
   always_comb begin
      length = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (flags[i]) begin
            length = LEN_W'(i + 1);
         end
      end
   end

endmodule

FILE: rtl/core/kmp_stream_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// An accepted request steps the cell row on its accepting edge; its second
// stage encodes the longest live prefix into the response register once that
// register is free, and only then is the next request taken.
// One more request is taken while a response waits on rsp_ready.
// Reset clears pattern length, prefix flags, found and all valid state;
// stored pattern symbols are not reset.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core
   import kmsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_match_end,
   output logic              rsp_found,
   output logic [LEN_W-1:0]  rsp_matched_length,
   output logic              rsp_pattern_overflow
);

   localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PATTERN);

   logic                   accept;
   logic                   is_append;
   logic                   is_text;
   logic                   is_clear;
   logic                   overflow;
   logic                   fire;
   cell_ctl_type           ctl;
   logic [MAX_PATTERN-1:0] chain;
   logic [MAX_PATTERN-1:0] flags;
   logic [MAX_PATTERN-1:0] tail_hits;
   logic [LEN_W-1:0]       live_len;
   logic                   found_next;

   logic             busy_ff,  busy_in;
   logic             text_ff;
   logic             clear_ff;
   logic             last_ff;
   logic             mend_ff;
   logic             ovf_ff;
   logic [LEN_W-1:0] len_ff,   len_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_mend_ff;
   logic             rsp_found_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_ovf_ff;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   // decode the request kind
   always_comb begin
      is_append = 1'b0;
      is_text   = 1'b0;
      is_clear  = 1'b0;
      unique case (kind_type'(req_kind))
         KIND_APPEND: is_append = 1'b1;
         KIND_TEXT:   is_text   = 1'b1;
         KIND_CLEAR:  is_clear  = 1'b1;
         default: ;
      endcase
   end

   assign overflow = is_append && (len_ff == MAX_L);

   // move the second stage into the response register when it is free
   assign fire = busy_ff && (!rsp_valid_ff || rsp_ready);

   assign ctl.step_text = accept && is_text;
   assign ctl.append    = accept && is_append && !overflow;
   assign ctl.clear     = accept && is_clear;
   assign ctl.drop      = fire && text_ff && last_ff;
   assign ctl.sym       = req_symbol;

   // cell row: the empty prefix always matches
   assign chain[0] = 1'b1;

   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      kmsm_cell #(
         .MAX_PATTERN (MAX_PATTERN),
         .IDX         (g),
         .LEN_W       (LEN_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .length    (len_ff),
         .prev_flag (chain[g]),
         .flag_ff   (flags[g]),
         .tail_hit  (tail_hits[g])
      );
      if (g > 0) begin : g_link
         assign chain[g] = flags[g-1];
      end
   end

   kmsm_encoder #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_encoder (
      .flags  (flags),
      .length (live_len)
   );

   // pattern length and stage-one bookkeeping
   always_comb begin
      len_in  = len_ff;
      busy_in = busy_ff;
      if (fire) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         if (is_clear) begin
            len_in = '0;
         end else if (is_append && !overflow) begin
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         len_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         len_ff  <= len_in;
      end
   end

   // hold the request's outcome for the second stage
   always_ff @(posedge clock) begin
      if (accept) begin
         text_ff  <= is_text;
         clear_ff <= is_clear;
         last_ff  <= req_last;
         mend_ff  <= is_text && ((len_ff == '0) || (|tail_hits));
         ovf_ff   <= overflow;
      end
   end

   // sticky found flag, cleared by a clear request or after the final symbol
   always_comb begin
      found_next = clear_ff ? 1'b0 : (found_ff || mend_ff);
      found_in   = found_ff;
      if (fire) begin
         found_in = (text_ff && last_ff) ? 1'b0 : found_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_mend_ff  <= mend_ff;
         rsp_found_ff <= found_next;
         rsp_len_ff   <= mend_ff ? len_ff : live_len;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_end        = rsp_mend_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_matched_length   = rsp_len_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

FILE: rtl/core/kmsm_checker.sv
// ----------------------------------------------------------------------------
// kmsm_checker
// Port-level checks for the streaming prefix matcher, bound to the top level.
// ----------------------------------------------------------------------------
module kmsm_checker
   import kmsm_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [KIND_W-1:0] req_kind,
   input logic [SYM_W-1:0]  req_symbol,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_match_end,
   input logic              rsp_found,
   input logic [LEN_W-1:0]  rsp_matched_length,
   input logic              rsp_pattern_overflow
);

   // hold a waiting request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kind)
         && $stable(req_symbol) && $stable(req_last))
      else $error("waiting request changed");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched_length)
         && $stable(rsp_match_end) && $stable(rsp_found))
      else $error("stalled response changed");

   // a match always raises the sticky found flag
   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_end |-> rsp_found)
      else $error("match without found");

   // a dropped pattern symbol is never a text match
   a_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_overflow |-> !rsp_match_end)
      else $error("overflow and match in one response");

   // one request in flight: no accept in the cycle after an accept
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("requests accepted back to back");

endmodule

bind kmp_stream_matcher_core kmsm_checker #(
   .LEN_W (LEN_W)
) u_kmsm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_kind             (req_kind),
   .req_symbol           (req_symbol),
   .req_last             (req_last),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_match_end        (rsp_match_end),
   .rsp_found            (rsp_found),
   .rsp_matched_length   (rsp_matched_length),
   .rsp_pattern_overflow (rsp_pattern_overflow)
);
